>>> src/fmtc_pkg.sv
// Shared types and constants for the frame marker transition confirmer.
package fmtc_pkg;

	// Default parameter values
	localparam int TIME_WIDTH_DEF = 48;
	localparam int SEQ_WIDTH_DEF  = 32;

	// Fixed field widths
	localparam int MARKER_W = 2;
	localparam int TICKS_W  = 32;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 3;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_CONFIRM_RUN = 1'b0,
		REG_GUARD_TICKS = 1'b1
	} reg_index_t;

	// Command codes
	typedef enum logic [1:0] {
		CMD_BEGIN   = 2'd0,
		CMD_OBSERVE = 2'd1,
		CMD_CHECK   = 2'd2,
		CMD_SPARE   = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OLD_FRAME = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_OBSERVING = 3'd2,
		ST_CONFIRMED = 3'd3,
		ST_ARMED     = 3'd4,
		ST_CHECKED   = 3'd5
	} status_t;

	// Reset values of the configuration registers
	localparam logic [COUNT_W-1:0] CONFIRM_RUN_RST = 8'd2;
	localparam logic [TICKS_W-1:0] GUARD_TICKS_RST = '0;

	// Status and flag fields of one result
	typedef struct packed {
		status_t             status;
		logic [MARKER_W-1:0] reported_marker;
		logic                timed_out;
		logic                is_confirmed;
		logic [MARKER_W-1:0] stable_marker;
	} flags_t;

endpackage

>>> src/fmtc_core.sv
// Confirmer state and the combinational evaluation of one item.
module fmtc_core #(
	parameter int TIME_WIDTH = fmtc_pkg::TIME_WIDTH_DEF,
	parameter int SEQ_WIDTH  = fmtc_pkg::SEQ_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  fmtc_pkg::cmd_t                 cmd,
	input  logic [fmtc_pkg::MARKER_W-1:0]  marker_expected,
	input  logic [TIME_WIDTH-1:0]          event_time,
	input  logic [fmtc_pkg::TICKS_W-1:0]   timeout_ticks,
	input  logic [SEQ_WIDTH-1:0]           frame_seq,
	input  logic [fmtc_pkg::MARKER_W-1:0]  marker_seen,
	input  logic [fmtc_pkg::COUNT_W-1:0]   confirm_run,
	input  logic [fmtc_pkg::TICKS_W-1:0]   guard_ticks,
	output fmtc_pkg::flags_t               flags,
	output logic [TIME_WIDTH-1:0]          confirm_time,
	output logic [TIME_WIDTH-1:0]          select_time
);
	import fmtc_pkg::*;

	localparam int SUM_W = ((TIME_WIDTH > TICKS_W) ? TIME_WIDTH : TICKS_W) + 1;

	// Add ticks to a time, saturating at the all-ones time
	function automatic logic [TIME_WIDTH-1:0] sat_add(
		input logic [TIME_WIDTH-1:0] a,
		input logic [TICKS_W-1:0]    b
	);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(a) + SUM_W'(b);
		if (|sum[SUM_W-1:TIME_WIDTH])
			return '1;
		return sum[TIME_WIDTH-1:0];
	endfunction

	logic [MARKER_W-1:0]  expected_q, expected_d;
	logic [TIME_WIDTH-1:0] show_q, show_d;
	logic [TIME_WIDTH-1:0] deadline_q, deadline_d;
	logic [COUNT_W-1:0]   match_q, match_d;
	logic                 trans_q, trans_d;
	logic                 conf_q, conf_d;
	logic [SEQ_WIDTH-1:0] seq_q, seq_d;
	logic                 seq_vld_q, seq_vld_d;
	logic [MARKER_W-1:0]  stable_q, stable_d;
	logic                 deadline_hit;

	// Evaluate the item and form the next state
	always_comb begin
		expected_d   = expected_q;
		show_d       = show_q;
		deadline_d   = deadline_q;
		match_d      = match_q;
		trans_d      = trans_q;
		conf_d       = conf_q;
		seq_d        = seq_q;
		seq_vld_d    = seq_vld_q;
		stable_d     = stable_q;
		flags        = '0;
		flags.status = ST_CHECKED;
		confirm_time = '0;
		select_time  = '0;
		deadline_hit = (event_time >= deadline_q);
		unique case (cmd)
			CMD_BEGIN: begin
				expected_d   = marker_expected;
				show_d       = event_time;
				deadline_d   = sat_add(event_time, timeout_ticks);
				match_d      = '0;
				trans_d      = (stable_q == '0);
				conf_d       = 1'b0;
				flags.status = ST_ARMED;
				// New deadline is never below the time; it equals it only here
				deadline_hit = (timeout_ticks == '0) || (&event_time);
			end
			CMD_OBSERVE: begin
				if (event_time < show_q) begin
					flags.status = ST_OLD_FRAME;
				end else if (seq_vld_q && frame_seq == seq_q) begin
					flags.status = ST_DUPLICATE;
				end else begin
					seq_d     = frame_seq;
					seq_vld_d = 1'b1;
					if (stable_q != '0 && marker_seen != stable_q)
						trans_d = 1'b1;
					if (marker_seen != expected_q && marker_seen != '0) begin
						trans_d = 1'b1;
						match_d = '0;
					end else if (marker_seen == expected_q && trans_d) begin
						if (!(&match_q))
							match_d = match_q + 1'b1;
					end else begin
						match_d = '0;
					end
					flags.reported_marker = marker_seen;
					if (trans_d && match_d >= confirm_run) begin
						stable_d     = expected_q;
						conf_d       = 1'b1;
						flags.status = ST_CONFIRMED;
						confirm_time = event_time;
						select_time  = sat_add(event_time, guard_ticks);
					end else begin
						flags.status = ST_OBSERVING;
					end
				end
			end
			default: begin
				// Check and the spare code change no state; they report the timeout, confirmation and stable marker
			end
		endcase
		flags.timed_out     = !conf_d && deadline_hit;
		flags.is_confirmed  = conf_d;
		flags.stable_marker = stable_d;
	end

	// Commit state for each evaluated item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			show_q     <= '0;
			deadline_q <= '0;
			match_q    <= '0;
			trans_q    <= 1'b0;
			conf_q     <= 1'b0;
			seq_q      <= '0;
			seq_vld_q  <= 1'b0;
			stable_q   <= '0;
		end else if (en) begin
			expected_q <= expected_d;
			show_q     <= show_d;
			deadline_q <= deadline_d;
			match_q    <= match_d;
			trans_q    <= trans_d;
			conf_q     <= conf_d;
			seq_q      <= seq_d;
			seq_vld_q  <= seq_vld_d;
			stable_q   <= stable_d;
		end
	end

endmodule

>>> src/frame_marker_transition_confirmer.sv
// Top level: stream ports, configuration registers, input and result registers.
// An accepted item is held in the input register, evaluated by combinational compare
// and count logic, and captured into the result register, from which it shows on m_*.
// Throughput: one item per cycle while m_tready does not stall a waiting result.
// An input register and a result register decouple the two sides, so one more item
// is taken while a finished result waits.
// Reset (arst_n low, asynchronous): no items held, state cleared, the confirmation
// run length back to 2 and guard_ticks to 0.
module frame_marker_transition_confirmer #(
	parameter int TIME_WIDTH = fmtc_pkg::TIME_WIDTH_DEF,
	parameter int SEQ_WIDTH  = fmtc_pkg::SEQ_WIDTH_DEF,
	localparam int IN_BITS   = 2 * fmtc_pkg::MARKER_W + TIME_WIDTH
	                           + fmtc_pkg::TICKS_W + SEQ_WIDTH,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = 2 * fmtc_pkg::MARKER_W + 2 * TIME_WIDTH + 2,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// marker_expected, event_time, timeout_ticks, frame_seq, marker_seen
	input  logic [IN_W-1:0]               s_tdata,
	// cmd
	input  logic [1:0]                    s_tuser,
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// reported_marker, confirm_time, select_time, timed_out, is_confirmed,
	// stable_marker
	output logic [OUT_W-1:0]              m_tdata,
	// status
	output logic [fmtc_pkg::STATUS_W-1:0] m_tuser,
	// Configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [0:0]                    cfg_index,
	input  logic [fmtc_pkg::TICKS_W-1:0]  cfg_data
);
	import fmtc_pkg::*;

	localparam int O_TIME = MARKER_W;
	localparam int O_TMO  = O_TIME + TIME_WIDTH;
	localparam int O_SEQ  = O_TMO + TICKS_W;
	localparam int O_SEEN = O_SEQ + SEQ_WIDTH;

	logic [COUNT_W-1:0]    confirm_run_q;
	logic [TICKS_W-1:0]    guard_ticks_q;

	logic                  vld_s1;
	cmd_t                  cmd_s1;
	logic [MARKER_W-1:0]   mexp_s1;
	logic [TIME_WIDTH-1:0] time_s1;
	logic [TICKS_W-1:0]    tmo_s1;
	logic [SEQ_WIDTH-1:0]  seq_s1;
	logic [MARKER_W-1:0]   seen_s1;

	logic                  vld_s2;
	flags_t                flags_s2;
	logic [TIME_WIDTH-1:0] ctime_s2;
	logic [TIME_WIDTH-1:0] stime_s2;

	flags_t                flags;
	logic [TIME_WIDTH-1:0] confirm_time;
	logic [TIME_WIDTH-1:0] select_time;
	logic                  advance;
	logic                  in_xfer;

	assign advance   = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready  = !vld_s1 || advance;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_run_q <= CONFIRM_RUN_RST;
			guard_ticks_q <= GUARD_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_CONFIRM_RUN: confirm_run_q <= cfg_data[COUNT_W-1:0];
				REG_GUARD_TICKS: guard_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	// Input register: unpack the transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= cmd_t'(s_tuser);
			mexp_s1 <= s_tdata[MARKER_W-1:0];
			time_s1 <= s_tdata[O_TMO-1:O_TIME];
			tmo_s1  <= s_tdata[O_SEQ-1:O_TMO];
			seq_s1  <= s_tdata[O_SEEN-1:O_SEQ];
			seen_s1 <= s_tdata[O_SEEN+MARKER_W-1:O_SEEN];
		end
	end

	fmtc_core #(
		.TIME_WIDTH (TIME_WIDTH),
		.SEQ_WIDTH  (SEQ_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.cmd             (cmd_s1),
		.marker_expected (mexp_s1),
		.event_time      (time_s1),
		.timeout_ticks   (tmo_s1),
		.frame_seq       (seq_s1),
		.marker_seen     (seen_s1),
		.confirm_run     (confirm_run_q),
		.guard_ticks     (guard_ticks_q),
		.flags           (flags),
		.confirm_time    (confirm_time),
		.select_time     (select_time)
	);

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (!vld_s2 || m_tready)
			vld_s2 <= vld_s1;
	end

	// Result register: capture the evaluated item
	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2 <= flags;
			ctime_s2 <= confirm_time;
			stime_s2 <= select_time;
		end
	end

	// Pack the result transfer
	assign m_tvalid = vld_s2;
	assign m_tuser  = flags_s2.status;
	assign m_tdata  = OUT_W'({flags_s2.stable_marker, flags_s2.is_confirmed,
	                          flags_s2.timed_out, stime_s2, ctime_s2,
	                          flags_s2.reported_marker});

endmodule

>>> src/fmtc_checker.sv
// Port-level checks on the result stream, bound to the top level.
module fmtc_checker #(
	parameter int TIME_WIDTH = fmtc_pkg::TIME_WIDTH_DEF,
	localparam int OUT_BITS  = 2 * fmtc_pkg::MARKER_W + 2 * TIME_WIDTH + 2,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [OUT_W-1:0]              m_tdata,
	input logic [fmtc_pkg::STATUS_W-1:0] m_tuser,
	input logic                          s_tvalid,
	input logic                          s_tready
);
	import fmtc_pkg::*;

	localparam int O_CTIME = MARKER_W;
	localparam int O_STIME = O_CTIME + TIME_WIDTH;
	localparam int O_TOUT  = O_STIME + TIME_WIDTH;
	localparam int O_CONF  = O_TOUT + 1;

	logic [TIME_WIDTH-1:0] ctime;
	logic [TIME_WIDTH-1:0] stime;
	logic                  tout;
	logic                  conf;
	logic                  in_xfer;

	assign ctime = m_tdata[O_STIME-1:O_CTIME];
	assign stime = m_tdata[O_TOUT-1:O_STIME];
	assign tout  = m_tdata[O_TOUT];
	assign conf  = m_tdata[O_CONF];
	assign in_xfer = s_tvalid && s_tready;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A confirmation sets the flag and never reports a timeout
	a_conf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_CONFIRMED |-> conf && !tout && stime >= ctime)
		else $error("confirmation fields inconsistent");

	// Times appear only with a confirmation
	a_times: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_CONFIRMED |-> ctime == '0 && stime == '0)
		else $error("times given without confirmation");

	// Arming clears the confirmation and reports no marker
	a_armed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_ARMED |-> !conf && m_tdata[MARKER_W-1:0] == '0)
		else $error("armed result inconsistent");

	// A result leaving an empty output follows an input transfer through the input and result registers
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_xfer, 2))
		else $error("result without input");

endmodule

bind frame_marker_transition_confirmer fmtc_checker #(
	.TIME_WIDTH (TIME_WIDTH)
) u_fmtc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready)
);
